FILE: rtl/cpsh_pkg.sv
// Shared types, constants and SHA-256 tables for the chained page hasher.
package cpsh_pkg;

    localparam int unsigned MAX_PAGE_TOKENS_DEF = 1024;
    localparam longint unsigned MAX_PATH_TOKENS_DEF = 64'd1048576;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [31:0] word_t;

    localparam word_t PAD_WORD = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] word;
        logic        word_present;
        logic        tok_end;
        logic        path_end;
    } cpsh_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WORD,
        ST_TOKEN,
        ST_PAD1,
        ST_PAD2,
        ST_EMIT,
        ST_PATH,
        ST_CLOAD,
        ST_ROUND,
        ST_CADD
    } eng_state_t;

    typedef enum logic [0:0] {
        REG_OVERRIDE = 1'b0,
        REG_SOURCE   = 1'b1
    } cfg_reg_t;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t init_h(logic [2:0] i);
        word_t r;
        unique case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(logic [5:0] i);
        word_t r;
        unique case (i)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/cpsh_front.sv
// Input front end: accepts words and queues them for the hash engine.
module cpsh_front
    import cpsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // word
    input  logic [1:0]  s_tuser,   // word_present, token end flag
    input  logic        s_tlast,   // path_end
    output logic        q_valid,
    input  logic        q_ready,
    output cpsh_item_t  q_item
);

    cpsh_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W:0]      count_reg;
    logic                 push;
    logic                 pop;

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{word: s_tdata, word_present: s_tuser[0],
                                     tok_end: s_tuser[1], path_end: s_tlast};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: rtl/cpsh_engine.sv
// Hash engine: page accounting, SHA-256 padding and round-per-cycle compression.
module cpsh_engine
    import cpsh_pkg::*;
#(
    parameter longint unsigned MAX_PATH_TOKENS = MAX_PATH_TOKENS_DEF
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    output logic         q_ready,
    input  cpsh_item_t   q_item,
    input  logic [10:0]  eff_size,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata
);

    localparam int TB_W = $clog2(MAX_PATH_TOKENS + 2);
    localparam int EW   = ((TB_W > 11) ? TB_W : 11) + 1;

    eng_state_t     state_reg, state_next;
    eng_state_t     ret_reg;
    cpsh_item_t     item_reg;
    word_t          buf_reg   [16];
    word_t          hash_reg  [8];
    word_t          prior_reg [8];
    word_t          wv_reg    [8];
    logic           has_prior_reg;
    logic [31:0]    byte_cnt_reg;
    logic [10:0]    tok_reg;
    logic [TB_W-1:0] base_reg;
    logic [TB_W-1:0] pages_reg;
    logic [5:0]     round_reg;
    logic           out_valid_reg;
    logic [319:0]   out_data_reg;

    logic [3:0]     slot;
    word_t          be_word;
    logic [10:0]    tok_inc;
    logic           page_full;
    word_t          len_hi, len_lo;
    logic [EW-1:0]  end_w;
    logic           fits;
    logic           can_load;
    logic           load_out;
    logic [63:0]    pages64, base64, end64;
    word_t          s0, s1, w_new, t1, t2, sig0, sig1, ch, maj;

    assign slot     = byte_cnt_reg[5:2];
    assign be_word  = {item_reg.word[7:0], item_reg.word[15:8],
                       item_reg.word[23:16], item_reg.word[31:24]};
    assign tok_inc  = (tok_reg == 11'h7ff) ? tok_reg : tok_reg + 11'd1;
    assign page_full = (tok_inc >= eff_size);
    assign len_hi   = {29'd0, byte_cnt_reg[31:29]};
    assign len_lo   = {byte_cnt_reg[28:0], 3'd0};
    assign end_w    = EW'(base_reg) + EW'(tok_reg);
    assign fits     = (end_w <= EW'(MAX_PATH_TOKENS));
    assign can_load = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_EMIT) && fits && can_load;
    assign pages64  = 64'(pages_reg);
    assign base64   = 64'(base_reg);
    assign end64    = 64'(end_w);

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // message schedule and round function
    assign s0    = rotr(buf_reg[1], 7) ^ rotr(buf_reg[1], 18) ^ (buf_reg[1] >> 3);
    assign s1    = rotr(buf_reg[14], 17) ^ rotr(buf_reg[14], 19) ^ (buf_reg[14] >> 10);
    assign w_new = buf_reg[0] + s0 + buf_reg[9] + s1;
    assign sig1  = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
    assign sig0  = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
    assign ch    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign maj   = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
    assign t1    = wv_reg[7] + sig1 + ch + round_k(round_reg) + buf_reg[0];
    assign t2    = sig0 + maj;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_WORD;
            ST_WORD:  state_next = (item_reg.word_present && slot == 4'hf) ? ST_CLOAD
                                                                          : ST_TOKEN;
            ST_TOKEN: state_next = (item_reg.tok_end && eff_size != '0 && page_full)
                                   ? ST_PAD1 : ST_PATH;
            ST_PAD1:  state_next = ST_CLOAD;
            ST_PAD2:  state_next = ST_CLOAD;
            ST_EMIT:  state_next = (fits && !can_load) ? ST_EMIT : ST_PATH;
            ST_PATH:  state_next = ST_IDLE;
            ST_CLOAD: state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_CADD;
            ST_CADD:  state_next = ret_reg;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {3'd0, end64[20:0], base64[19:0], pages64[19:0],
                             hash_reg[6], hash_reg[7], hash_reg[4], hash_reg[5],
                             hash_reg[2], hash_reg[3], hash_reg[0], hash_reg[1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            has_prior_reg <= 1'b0;
            byte_cnt_reg  <= '0;
            tok_reg       <= '0;
            base_reg      <= '0;
            pages_reg     <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i]  <= init_h(3'(i));
                prior_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_out)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) item_reg <= q_item;
                end
                ST_WORD: begin
                    if (item_reg.word_present) begin
                        buf_reg[slot] <= be_word;
                        byte_cnt_reg  <= byte_cnt_reg + 32'd4;
                        ret_reg       <= ST_TOKEN;
                    end
                end
                ST_TOKEN: begin
                    if (item_reg.tok_end) begin
                        if (eff_size == '0) begin
                            tok_reg <= '0;
                            for (int i = 0; i < 8; i++) begin
                                hash_reg[i] <= init_h(3'(i));
                                buf_reg[i]  <= prior_reg[i];
                            end
                            byte_cnt_reg <= has_prior_reg ? 32'd32 : 32'd0;
                        end else begin
                            tok_reg <= tok_inc;
                        end
                    end
                end
                ST_PAD1: begin
                    // pad word then length; with no room for the length after the pad word, spill into a second block
                    for (int i = 0; i < 16; i++) begin
                        if (4'(i) == slot) begin
                            buf_reg[i] <= PAD_WORD;
                        end else if (4'(i) > slot) begin
                            if (slot >= 4'd14) buf_reg[i] <= '0;
                            else if (i == 14)  buf_reg[i] <= len_hi;
                            else if (i == 15)  buf_reg[i] <= len_lo;
                            else               buf_reg[i] <= '0;
                        end
                    end
                    ret_reg <= (slot >= 4'd14) ? ST_PAD2 : ST_EMIT;
                end
                ST_PAD2: begin
                    for (int i = 0; i < 14; i++) buf_reg[i] <= '0;
                    buf_reg[14] <= len_hi;
                    buf_reg[15] <= len_lo;
                    ret_reg     <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!(fits && !can_load)) begin
                        has_prior_reg <= 1'b1;
                        base_reg  <= fits ? end_w[TB_W-1:0] : TB_W'(MAX_PATH_TOKENS + 1);
                        pages_reg <= pages_reg + 1'b1;
                        tok_reg   <= '0;
                        for (int i = 0; i < 8; i++) begin
                            prior_reg[i] <= hash_reg[i];
                            buf_reg[i]   <= hash_reg[i];
                            hash_reg[i]  <= init_h(3'(i));
                        end
                        byte_cnt_reg <= 32'd32;
                    end
                end
                ST_PATH: begin
                    if (item_reg.path_end) begin
                        has_prior_reg <= 1'b0;
                        tok_reg       <= '0;
                        pages_reg     <= '0;
                        base_reg      <= '0;
                        byte_cnt_reg  <= '0;
                        for (int i = 0; i < 8; i++) begin
                            prior_reg[i] <= '0;
                            hash_reg[i]  <= init_h(3'(i));
                        end
                    end
                end
                ST_CLOAD: begin
                    for (int i = 0; i < 8; i++) wv_reg[i] <= hash_reg[i];
                    round_reg <= '0;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) buf_reg[i] <= buf_reg[i+1];
                    buf_reg[15] <= w_new;
                    wv_reg[0] <= t1 + t2;
                    wv_reg[1] <= wv_reg[0];
                    wv_reg[2] <= wv_reg[1];
                    wv_reg[3] <= wv_reg[2];
                    wv_reg[4] <= wv_reg[3] + t1;
                    wv_reg[5] <= wv_reg[4];
                    wv_reg[6] <= wv_reg[5];
                    wv_reg[7] <= wv_reg[6];
                    round_reg <= round_reg + 6'd1;
                end
                ST_CADD: begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/chained_page_sha256.sv
// Top level of the chained page SHA-256 hasher with its APB register port.
//
// Words of a token path enter on the s_ stream, one 32-bit word per word
// transfer; tuser flags a present word and a token end, tlast ends the path.
// Each full page of tokens within MAX_PATH_TOKENS gives one 320-bit result word on the m_ stream:
// the 32-byte digest, the page index and the page's token range.
// Page size comes from two APB registers (override at 0x0, source at 0x4).
// The engine sequencer takes each word through its idle, word, token and
// path states; a word that fills a 64-byte block adds a compression (load,
// 64 rounds, feed-forward). A closing page adds one or two padding blocks,
// each with a pad state and a compression, plus an emit state that loads
// the result. The single round unit sets the word rate, and the engine takes
// no new word from the queue while it compresses.
// A 4-entry input queue lets the source run ahead during compressions.
// Reset clears the chain, counters and queue; the hash state returns to its
// initial value. If the receiver stalls, one result waits in the output
// register and the engine halts only when the next page must be delivered.
module chained_page_sha256
    import cpsh_pkg::*;
#(
    parameter int unsigned     MAX_PAGE_TOKENS = MAX_PAGE_TOKENS_DEF,
    parameter longint unsigned MAX_PATH_TOKENS = MAX_PATH_TOKENS_DEF
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // word
    input  logic [1:0]   s_tuser,   // word_present, token end flag
    input  logic         s_tlast,   // path_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // digest_0..3, page_number, first_token, end_token
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [10:0] override_reg;
    logic [10:0] source_reg;
    logic [10:0] raw_size;
    logic [10:0] eff_size;
    logic        q_valid;
    logic        q_ready;
    cpsh_item_t  q_item;
    cfg_reg_t    sel;

    assign pready = 1'b1;
    assign sel    = cfg_reg_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            override_reg <= '0;
            source_reg   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                REG_OVERRIDE: override_reg <= pwdata[10:0];
                REG_SOURCE:   source_reg   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_OVERRIDE: prdata = {21'd0, override_reg};
            REG_SOURCE:   prdata = {21'd0, source_reg};
            default:      prdata = '0;
        endcase
    end

    assign raw_size = (override_reg != '0) ? override_reg : source_reg;
    assign eff_size = (32'(raw_size) > 32'(MAX_PAGE_TOKENS)) ? 11'(MAX_PAGE_TOKENS)
                                                              : raw_size;

    cpsh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    cpsh_engine #(
        .MAX_PATH_TOKENS (MAX_PATH_TOKENS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .eff_size  (eff_size),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: verif/cpsh_checker.sv
// Checker for the chained page hasher: predicts page digests and compares results.
module cpsh_checker
    import cpsh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [319:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pages_pending,
    output int           pages_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] dg [4];
        logic [19:0] page_number;
        logic [19:0] first_token;
        logic [20:0] end_token;
    } page_rec_t;

    page_rec_t page_q [$];

    logic [31:0] kt [0:63];
    logic [31:0] iv [0:7];
    logic [31:0] hs [0:7];
    logic [31:0] blk [0:15];
    logic [31:0] chain [0:7];
    logic        chained;
    logic [31:0] msg_bytes;
    logic [10:0] page_tokens;
    longint unsigned page_idx;
    longint unsigned tok_base;
    logic [10:0] ovr_size;
    logic [10:0] src_size;

    initial begin
        kt = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    end

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void sha_compress();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = hs[0]; b = hs[1]; c = hs[2]; d = hs[3];
        e = hs[4]; f = hs[5]; g = hs[6]; h = hs[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + kt[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hs[0] += a; hs[1] += b; hs[2] += c; hs[3] += d;
        hs[4] += e; hs[5] += f; hs[6] += g; hs[7] += h;
    endfunction

    function void absorb_word(logic [31:0] be);
        logic [3:0] slot;
        slot = msg_bytes[5:2];
        blk[slot] = be;
        msg_bytes += 32'd4;
        if (slot == 4'd15) sha_compress();
    endfunction

    function void open_page();
        for (int i = 0; i < 8; i++) hs[i] = iv[i];
        msg_bytes = '0;
        if (chained) for (int i = 0; i < 8; i++) absorb_word(chain[i]);
    endfunction

    function void close_page();
        logic [63:0] bits;
        int n;
        bits = 64'(msg_bytes) << 3;
        n = int'(msg_bytes[5:2]);
        blk[n] = PAD_WORD;
        n++;
        if (n > 14) begin
            while (n < 16) begin
                blk[n] = '0;
                n++;
            end
            sha_compress();
            n = 0;
        end
        while (n < 14) begin
            blk[n] = '0;
            n++;
        end
        blk[14] = bits[63:32];
        blk[15] = bits[31:0];
        sha_compress();
    endfunction

    function void clear_path();
        for (int i = 0; i < 8; i++) chain[i] = '0;
        chained = 1'b0;
        page_tokens = '0;
        page_idx = 0;
        tok_base = 0;
        open_page();
    endfunction

    function void predict_word(logic [31:0] wd, logic wp, logic te, logic pe);
        logic [10:0] psz;
        longint unsigned last_tok;
        page_rec_t r;
        if (wp) absorb_word({wd[7:0], wd[15:8], wd[23:16], wd[31:24]});
        if (te) begin
            psz = (ovr_size != 0) ? ovr_size : src_size;
            if (psz > 11'd1024) psz = 11'd1024;
            if (page_tokens != 11'h7ff) page_tokens++;
            if (psz == 0) begin
                page_tokens = '0;
                open_page();
            end else if (page_tokens >= psz) begin
                last_tok = tok_base + page_tokens;
                close_page();
                if (last_tok <= MAX_PATH_TOKENS_DEF) begin
                    for (int i = 0; i < 4; i++) r.dg[i] = {hs[2*i], hs[2*i+1]};
                    r.page_number = page_idx[19:0];
                    r.first_token = tok_base[19:0];
                    r.end_token = last_tok[20:0];
                    page_q.insert(page_q.size(), r);
                end
                for (int i = 0; i < 8; i++) chain[i] = hs[i];
                chained = 1'b1;
                tok_base = last_tok;
                page_idx++;
                page_tokens = '0;
                open_page();
            end
        end
        if (pe) clear_path();
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        page_rec_t r;
        if (!aresetn) begin
            ovr_size <= '0;
            src_size <= '0;
            chained = 1'b0;
            page_q.delete();
            fail_count = 0;
            pages_seen <= 0;
            clear_path();
        end else begin
            if (m_tvalid && m_tready) begin
                pages_seen <= pages_seen + 1;
                if (page_q.size() == 0) begin
                    $error("page result with none expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    r = page_q.pop_front();
                    check_field("digest_0", r.dg[0], m_tdata[63:0]);
                    check_field("digest_1", r.dg[1], m_tdata[127:64]);
                    check_field("digest_2", r.dg[2], m_tdata[191:128]);
                    check_field("digest_3", r.dg[3], m_tdata[255:192]);
                    check_field("page_number", 64'(r.page_number), 64'(m_tdata[275:256]));
                    check_field("first_token", 64'(r.first_token), 64'(m_tdata[295:276]));
                    check_field("end_token", 64'(r.end_token), 64'(m_tdata[316:296]));
                end
            end
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tuser[0], s_tuser[1], s_tlast);
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_OVERRIDE, 2'b00}) ovr_size <= pwdata[10:0];
                else if (paddr == {REG_SOURCE, 2'b00}) src_size <= pwdata[10:0];
            end
        end
        pages_pending <= page_q.size();
    end

endmodule

FILE: verif/testbench.sv
// Top of the chained page hasher testbench: clock, reset, stimulus and verdict.
module testbench
    import cpsh_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pages_pending;
    int pages_seen;
    int words_sent;
    int cfg_writes;
    logic quiet;

    chained_page_sha256 u_dut (.*);

    cpsh_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pages_pending(pages_pending), .pages_seen(pages_seen)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("chained_page_sha256: mismatch");
        $finish;
    end

    // result side: long hold-off first so the input queue backs up, then random stalls
    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        hold = 0;
        while (hold < 3000) begin
            @(posedge aclk);
            hold++;
        end
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(logic [31:0] wd, logic wp, logic te, logic pe);
        s_tvalid <= 1'b1;
        s_tdata <= wd;
        s_tuser <= {te, wp};
        s_tlast <= pe;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (wp || te || pe) words_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic reg_write(cfg_reg_t idx, logic [10:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {21'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_writes++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pages_pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic send_token(int nwords);
        logic close_with_word;
        close_with_word = (nwords > 0) && $urandom_range(0, 1);
        for (int i = 0; i < nwords - (close_with_word ? 1 : 0); i++)
            send_word($urandom, 1'b1, 1'b0, 1'b0);
        if (close_with_word) send_word($urandom, 1'b1, 1'b1, 1'b0);
        else send_word($urandom, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic random_path(bit finish);
        int ntok;
        ntok = $urandom_range(1, 14);
        for (int t = 0; t < ntok; t++) begin
            if ($urandom_range(0, 9) == 0) send_word($urandom, 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 7) == 0) send_token($urandom_range(5, 40));
            else send_token($urandom_range(0, 4));
        end
        // broken paths: early end in the middle of a token; otherwise a finishing path ends on a random word
        if ($urandom_range(0, 5) == 0) send_word($urandom, 1'b1, 1'b0, 1'b1);
        else if (finish) send_word($urandom, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 1'b1);
    endtask

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd1024;
            2: return 11'd1023;
            3: return 11'($urandom_range(0, 1024));
            default: return 11'($urandom_range(1, 5));
        endcase
    endfunction

    initial begin
        int phase;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        words_sent = 0;
        cfg_writes = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // page size zero: token end discards, nothing comes out
        send_word(32'hffffffff, 1'b1, 1'b1, 1'b0);
        send_word(32'h00000000, 1'b0, 1'b1, 1'b0);
        drain();
        reg_write(REG_SOURCE, 11'd2);
        // empty token, extreme words, chained second page, ignored word in a boundary item
        send_word(32'hdeadbeef, 1'b0, 1'b1, 1'b0);
        send_word(32'h00000000, 1'b1, 1'b1, 1'b0);
        send_word(32'hffffffff, 1'b1, 1'b0, 1'b0);
        send_word(32'h12345678, 1'b1, 1'b1, 1'b0);
        send_word(32'h55aa55aa, 1'b0, 1'b1, 1'b0);
        send_word(32'haa55aa55, 1'b1, 1'b1, 1'b0);
        send_word(32'h0f0f0f0f, 1'b1, 1'b1, 1'b1);
        send_word(32'h00000000, 1'b0, 1'b0, 1'b1);
        send_word(32'h87654321, 1'b1, 1'b1, 1'b0);
        drain();
        // override wins; the page already holds one token
        reg_write(REG_OVERRIDE, 11'd1);
        send_word(32'h80000001, 1'b1, 1'b1, 1'b0);
        send_word(32'h7ffffffe, 1'b1, 1'b1, 1'b1);
        drain();
        // largest page size, override wins over the source; the path is left open so the next size lowers it
        reg_write(REG_OVERRIDE, 11'd1024);
        reg_write(REG_SOURCE, 11'd1023);
        send_word(32'hcafef00d, 1'b1, 1'b1, 1'b0);
        send_word(32'h0badf00d, 1'b1, 1'b1, 1'b0);
        drain();
        reg_write(REG_OVERRIDE, 11'd0);
        reg_write(REG_SOURCE, 11'd1);
        send_word(32'h13579bdf, 1'b1, 1'b1, 1'b0);

        phase = 0;
        while (words_sent < 1050) begin
            if (words_sent > 900) quiet = 1'b1;
            if (words_sent >= 150 * (phase + 1)) begin
                phase++;
                drain();
                reg_write(REG_OVERRIDE, pick_size());
                reg_write(REG_SOURCE, pick_size());
            end
            random_path($urandom_range(0, 4) != 0);
        end
        drain();

        $display("%0d words sent over %0d register writes; %0d pages hashed and compared",
                 words_sent, cfg_writes, pages_seen);
        if (fail_count == 0 && pages_pending == 0) begin
            $display("chained_page_sha256: match");
        end else begin
            $display("chained_page_sha256: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/cpsh_pkg.sv
rtl/cpsh_front.sv
rtl/cpsh_engine.sv
rtl/chained_page_sha256.sv
verif/cpsh_checker.sv
verif/testbench.sv
